@@ design/dtps_pkg.sv @@
// Shared constants, codes and types of the disc track playback sequencer.
package dtps_pkg;

  // Table geometry and chunk size
  localparam int TRACK_COUNT = 32;
  localparam int CHUNK_BYTES = 18816;
  localparam int TRACK_IDX_W = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;

  // Field widths
  localparam int ADDR_W      = 30;
  localparam int ACTION_W    = 3;
  localparam int INDEX_W     = 8;
  localparam int KIND_W      = 2;
  localparam int TRACK_OUT_W = 5;
  localparam int STATUS_W    = 2;
  localparam int EVENT_W     = 2;

  // Derived constants
  localparam logic [INDEX_W-1:0]     INDEX_LIMIT = INDEX_W'(TRACK_COUNT);
  localparam logic [TRACK_IDX_W-1:0] LAST_TRACK  = TRACK_IDX_W'(TRACK_COUNT - 1);
  localparam logic [ADDR_W:0]        CHUNK_ADD   = (ADDR_W + 1)'(CHUNK_BYTES);

  // Action codes on the input channel
  localparam logic [ACTION_W-1:0] ACT_LOAD   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PLAY   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_STOP   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_PAUSE  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_RESUME = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_TICK   = 3'd5;

  // Track kinds
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OTHER = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BAD   = 2'd3;

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_LOAD,
    OP_PLAY,
    OP_STOP,
    OP_RESUME,
    OP_TICK,
    OP_NOP
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    MODE_STOPPED = 2'd0,
    MODE_PLAYING = 2'd1,
    MODE_PENDING = 2'd2
  } mode_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE     = 2'd0,
    EV_LOOPED   = 2'd1,
    EV_ADVANCED = 2'd2,
    EV_STOPPED  = 2'd3
  } event_t;

  typedef struct packed {
    op_t                    op;
    logic                   in_range;
    logic [TRACK_IDX_W-1:0] idx;
    logic [ADDR_W-1:0]      offset;
    logic [KIND_W-1:0]      kind;
    logic                   loop_flag;
  } cmd_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

endpackage

@@ design/dtps_if.sv @@
// Valid/ready channel interfaces for the command and result words.
interface dtps_in_if;
  logic                           valid;
  logic                           ready;
  logic [dtps_pkg::ACTION_W-1:0]  action;
  logic [dtps_pkg::INDEX_W-1:0]   track_index;
  logic [dtps_pkg::ADDR_W-1:0]    entry_offset;
  logic [dtps_pkg::KIND_W-1:0]    entry_kind;
  logic                           loop_flag;

  modport source (
    output valid, action, track_index, entry_offset, entry_kind, loop_flag,
    input  ready
  );
  modport sink (
    input  valid, action, track_index, entry_offset, entry_kind, loop_flag,
    output ready
  );
endinterface

interface dtps_out_if;
  logic                              valid;
  logic                              ready;
  logic                              read_valid;
  logic [dtps_pkg::ADDR_W-1:0]       read_address;
  logic [dtps_pkg::TRACK_OUT_W-1:0]  playing_track;
  logic [dtps_pkg::STATUS_W-1:0]     play_status;
  logic [dtps_pkg::EVENT_W-1:0]      end_event;
  logic                              rejected;

  modport source (
    output valid, read_valid, read_address, playing_track, play_status, end_event,
           rejected,
    input  ready
  );
  modport sink (
    input  valid, read_valid, read_address, playing_track, play_status, end_event,
           rejected,
    output ready
  );
endinterface

@@ design/dtps_front.sv @@
// Front end: accepts command words, classifies them and queues them for the back end.
module dtps_front (
  input  logic            clk,
  input  logic            rst_n,
  dtps_in_if.sink         in_ch,
  input  logic            pop,
  output dtps_pkg::head_t head
);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  dtps_pkg::cmd_t    queue_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  dtps_pkg::cmd_t    cmd;
  logic              push;

  // Classify the incoming word
  always_comb begin
    cmd.in_range  = in_ch.track_index < dtps_pkg::INDEX_LIMIT;
    cmd.idx       = in_ch.track_index[dtps_pkg::TRACK_IDX_W-1:0];
    cmd.offset    = in_ch.entry_offset;
    cmd.kind      = (in_ch.entry_kind == dtps_pkg::KIND_BAD) ? dtps_pkg::KIND_OTHER
                                                             : in_ch.entry_kind;
    cmd.loop_flag = in_ch.loop_flag;
    case (in_ch.action)
      dtps_pkg::ACT_LOAD:                      cmd.op = dtps_pkg::OP_LOAD;
      dtps_pkg::ACT_PLAY:                      cmd.op = dtps_pkg::OP_PLAY;
      dtps_pkg::ACT_STOP, dtps_pkg::ACT_PAUSE: cmd.op = dtps_pkg::OP_STOP;
      dtps_pkg::ACT_RESUME:                    cmd.op = dtps_pkg::OP_RESUME;
      dtps_pkg::ACT_TICK:                      cmd.op = dtps_pkg::OP_TICK;
      default:                                 cmd.op = dtps_pkg::OP_NOP;
    endcase
  end

  // Queue pointers and fill level
  assign in_ch.ready = (count_r != (QPTR_W + 1)'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold the queued words
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= cmd;
    end
  end

  assign head.valid = (count_r != '0);
  assign head.cmd   = queue_r[rd_ptr_r];

endmodule

@@ design/dtps_back.sv @@
// Back end: track table, playback state and the registered result word.
module dtps_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [dtps_pkg::ADDR_W-1:0]   cfg_wdata,
  input  dtps_pkg::head_t               head,
  output logic                          pop,
  output logic                          exec,
  dtps_out_if.source                    out_ch
);

  localparam int TRACK_OUT_W = dtps_pkg::TRACK_OUT_W;

  typedef struct packed {
    logic [dtps_pkg::ADDR_W-1:0] start;
    logic [dtps_pkg::KIND_W-1:0] kind;
  } entry_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // Track table memory, one write and two registered reads
  entry_t                              mem [dtps_pkg::TRACK_COUNT];
  logic                                mem_we;
  logic [dtps_pkg::TRACK_IDX_W-1:0]    rd_addr1;
  entry_t                              rd_cur_r, rd_nxt_r;
  logic                                cur_ok_r, nxt_ok_r;

  // Control and playback state
  state_t                              state_r, state_nxt;
  dtps_pkg::mode_t                     mode_r, mode_nxt;
  logic [dtps_pkg::TRACK_IDX_W-1:0]    track_r, track_nxt;
  logic                                repeat_r, repeat_nxt;
  logic [dtps_pkg::ADDR_W-1:0]         pos_r, pos_nxt;
  logic [dtps_pkg::ADDR_W-1:0]         disc_size_r;
  logic [dtps_pkg::TRACK_COUNT-1:0]    entry_ok_r, entry_ok_nxt;

  // Result register
  logic                                out_valid_r, out_valid_nxt;
  logic                                out_rvalid_r;
  logic [dtps_pkg::ADDR_W-1:0]         out_raddr_r;
  logic [TRACK_OUT_W-1:0]              out_track_r;
  dtps_pkg::mode_t                     out_status_r;
  dtps_pkg::event_t                    out_event_r;
  logic                                out_rej_r;

  // Result of the current step
  logic                                res_fire;
  logic                                res_rvalid;
  logic [dtps_pkg::ADDR_W-1:0]         res_addr;
  dtps_pkg::event_t                    res_event;
  logic                                res_rej;

  // Tick datapath
  logic [dtps_pkg::ADDR_W-1:0]         cur_start, nxt_start, base, trk_end;
  logic [dtps_pkg::KIND_W-1:0]         cur_kind, nxt_kind;
  logic [dtps_pkg::ADDR_W:0]           npos;
  logic                                is_last, passed, slot_free;

  assign is_last  = (track_r == dtps_pkg::LAST_TRACK);
  assign rd_addr1 = is_last ? track_r : track_r + 1'b1;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[head.cmd.idx] <= '{start: head.cmd.offset, kind: head.cmd.kind};
    end
    rd_cur_r <= mem[track_r];
    rd_nxt_r <= mem[rd_addr1];
    cur_ok_r <= entry_ok_r[track_r];
    nxt_ok_r <= entry_ok_r[rd_addr1];
  end

  // Unwritten entries read as empty at offset zero
  assign cur_start = cur_ok_r ? rd_cur_r.start : '0;
  assign cur_kind  = cur_ok_r ? rd_cur_r.kind  : dtps_pkg::KIND_EMPTY;
  assign nxt_start = nxt_ok_r ? rd_nxt_r.start : '0;
  assign nxt_kind  = nxt_ok_r ? rd_nxt_r.kind  : dtps_pkg::KIND_EMPTY;

  // Track end, advanced position and end test
  always_comb begin
    base = (mode_r == dtps_pkg::MODE_PENDING) ? cur_start : pos_r;
    npos = {1'b0, base} + dtps_pkg::CHUNK_ADD;
    if (cur_kind == dtps_pkg::KIND_EMPTY) begin
      trk_end = cur_start;
    end else if (is_last || nxt_kind == dtps_pkg::KIND_EMPTY) begin
      trk_end = disc_size_r;
    end else begin
      trk_end = nxt_start;
    end
    passed = npos[dtps_pkg::ADDR_W] || (npos[dtps_pkg::ADDR_W-1:0] > trk_end);
  end

  // Step the sequencer
  assign slot_free = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    track_nxt     = track_r;
    repeat_nxt    = repeat_r;
    pos_nxt       = pos_r;
    entry_ok_nxt  = entry_ok_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    pop           = 1'b0;
    mem_we        = 1'b0;
    res_fire      = 1'b0;
    res_rvalid    = 1'b0;
    res_addr      = '0;
    res_event     = dtps_pkg::EV_NONE;
    res_rej       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (head.valid && slot_free) begin
          pop      = 1'b1;
          res_fire = 1'b1;
          case (head.cmd.op)
            dtps_pkg::OP_LOAD: begin
              if (head.cmd.in_range) begin
                mem_we                    = 1'b1;
                entry_ok_nxt[head.cmd.idx] = 1'b1;
              end
            end
            dtps_pkg::OP_PLAY: begin
              if (head.cmd.in_range) begin
                mode_nxt   = dtps_pkg::MODE_PENDING;
                track_nxt  = head.cmd.idx;
                repeat_nxt = head.cmd.loop_flag;
              end else begin
                res_rej = 1'b1;
              end
            end
            dtps_pkg::OP_STOP:   mode_nxt = dtps_pkg::MODE_STOPPED;
            dtps_pkg::OP_RESUME: mode_nxt = dtps_pkg::MODE_PLAYING;
            dtps_pkg::OP_TICK: begin
              // a stopped block answers with silence at once
              if (mode_r != dtps_pkg::MODE_STOPPED) begin
                res_fire  = 1'b0;
                state_nxt = S_EXEC;
              end
            end
            default: ;
          endcase
        end
      end
      S_EXEC: begin
        state_nxt  = S_IDLE;
        res_fire   = 1'b1;
        res_rvalid = 1'b1;
        res_addr   = base;
        mode_nxt   = dtps_pkg::MODE_PLAYING;
        if (!passed) begin
          pos_nxt = npos[dtps_pkg::ADDR_W-1:0];
        end else if (repeat_r) begin
          pos_nxt   = cur_start;
          res_event = dtps_pkg::EV_LOOPED;
        end else begin
          // saturate on overflow, keep reading on into the next track
          pos_nxt = npos[dtps_pkg::ADDR_W] ? '1 : npos[dtps_pkg::ADDR_W-1:0];
          if (is_last) begin
            mode_nxt  = dtps_pkg::MODE_STOPPED;
            res_event = dtps_pkg::EV_STOPPED;
          end else begin
            track_nxt = track_r + 1'b1;
            if (nxt_kind == dtps_pkg::KIND_EMPTY) begin
              mode_nxt  = dtps_pkg::MODE_STOPPED;
              res_event = dtps_pkg::EV_STOPPED;
            end else begin
              res_event = dtps_pkg::EV_ADVANCED;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (res_fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  // State, playback registers and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= dtps_pkg::MODE_STOPPED;
      track_r     <= '0;
      repeat_r    <= 1'b0;
      pos_r       <= '0;
      disc_size_r <= '0;
      entry_ok_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      track_r     <= track_nxt;
      repeat_r    <= repeat_nxt;
      pos_r       <= pos_nxt;
      entry_ok_r  <= entry_ok_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        disc_size_r <= cfg_wdata;
      end
    end
    if (res_fire) begin
      out_rvalid_r <= res_rvalid;
      out_raddr_r  <= res_addr;
      out_track_r  <= TRACK_OUT_W'(track_nxt);
      out_status_r <= mode_nxt;
      out_event_r  <= res_event;
      out_rej_r    <= res_rej;
    end
  end

  assign exec                 = (state_r == S_EXEC);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.read_valid    = out_rvalid_r;
  assign out_ch.read_address  = out_raddr_r;
  assign out_ch.playing_track = out_track_r;
  assign out_ch.play_status   = out_status_r;
  assign out_ch.end_event     = out_event_r;
  assign out_ch.rejected      = out_rej_r;

endmodule

@@ design/disc_track_playback_sequencer.sv @@
// Top level of the disc track playback sequencer: front end, queue and back end.
//
//   channel   direction  handshake          payload
//   in_ch     in         valid/ready        action, track_index, entry_offset,
//                                           entry_kind, loop_flag
//   out_ch    out        valid/ready        read_valid, read_address, playing_track,
//                                           play_status, end_event, rejected
//   cfg       in         cfg_we             cfg_wdata (disc size, 30 bits)
//
// Every command word gives exactly one result word.
// A tick of a playing block does the registered read of the current and next table
// entries in S_IDLE, then the end test and update in S_EXEC.
// Every other word, and a tick of a stopped block, is finished in S_IDLE.
// Reset is synchronous: table entries read as empty at once, with no sweep.
// A two-word queue decouples intake from execution; a stalled result holds
// the back end while the front keeps taking words until the queue is full.
module disc_track_playback_sequencer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [dtps_pkg::ADDR_W-1:0] cfg_wdata,
  dtps_in_if.sink                     in_ch,
  dtps_out_if.source                  out_ch
);

  dtps_pkg::head_t q_head;
  logic            q_pop;
  logic            exec;

  dtps_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .pop   (q_pop),
    .head  (q_head)
  );

  dtps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .head      (q_head),
    .pop       (q_pop),
    .exec      (exec),
    .out_ch    (out_ch)
  );

  // Back end never pops an empty queue
  a_pop_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head.valid)
    else $error("queue popped while empty");

  // Result slot is free while a tick is being worked out
  a_exec_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    exec |-> !out_ch.valid)
    else $error("result register busy during tick execution");

  // A chunk read always leaves the block out of the pending state
  a_read_not_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.read_valid) |-> (out_ch.play_status != dtps_pkg::MODE_PENDING))
    else $error("pending status after a chunk read");

  // End events only come with a chunk read
  a_event_has_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.end_event != dtps_pkg::EV_NONE) |-> out_ch.read_valid)
    else $error("end event without a chunk read");

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the disc track playback sequencer.
`timescale 1ns / 1ps

module testbench;
  import dtps_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_SLACK  = 8;
  localparam int PHASE_COUNT  = 8;
  localparam int RANDOM_WORDS = 118;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [INDEX_W-1:0]  track_index;
    logic [ADDR_W-1:0]   entry_offset;
    logic [KIND_W-1:0]   entry_kind;
    logic                loop_flag;
  } command_word_t;

  typedef struct packed {
    logic                   read_valid;
    logic [ADDR_W-1:0]      read_address;
    logic [TRACK_OUT_W-1:0] playing_track;
    logic [STATUS_W-1:0]    play_status;
    logic [EVENT_W-1:0]     end_event;
    logic                   rejected;
  } status_word_t;

  // Track table and transport state, advanced once per accepted command word
  class playback_scoreboard;
    logic [ADDR_W-1:0]      start_tab [TRACK_COUNT];
    logic [KIND_W-1:0]      kind_tab  [TRACK_COUNT];
    mode_t                  mode;
    logic [TRACK_IDX_W-1:0] cur_track;
    logic                   repeat_on;
    logic [ADDR_W-1:0]      position;
    logic [ADDR_W-1:0]      disc_size;
    status_word_t           pending_status [$];
    int                     fail_count;

    function new();
      foreach (start_tab[i]) begin
        start_tab[i] = '0;
        kind_tab[i]  = KIND_EMPTY;
      end
      mode       = MODE_STOPPED;
      cur_track  = '0;
      repeat_on  = 1'b0;
      position   = '0;
      disc_size  = '0;
      fail_count = 0;
    endfunction

    function void set_disc_size(logic [ADDR_W-1:0] v);
      disc_size = v;
    endfunction

    function bit idle();
      return pending_status.size() == 0;
    endfunction

    // Work out the status word that one command word produces
    function void note_command(command_word_t c);
      status_word_t           e;
      logic [ADDR_W:0]        next_pos;
      logic [ADDR_W-1:0]      end_addr;
      logic [TRACK_IDX_W-1:0] slot;
      logic                   is_last;
      e    = '0;
      slot = c.track_index[TRACK_IDX_W-1:0];
      case (c.action)
        ACT_LOAD: begin
          if (c.track_index < TRACK_COUNT) begin
            start_tab[slot] = c.entry_offset;
            kind_tab[slot]  = (c.entry_kind == KIND_BAD) ? KIND_OTHER : c.entry_kind;
          end
        end
        ACT_PLAY: begin
          if (c.track_index < TRACK_COUNT) begin
            mode      = MODE_PENDING;
            cur_track = slot;
            repeat_on = c.loop_flag;
          end else begin
            e.rejected = 1'b1;
          end
        end
        ACT_STOP, ACT_PAUSE: mode = MODE_STOPPED;
        ACT_RESUME: mode = MODE_PLAYING;
        ACT_TICK: begin
          if (mode != MODE_STOPPED) begin
            // a pending play seeks to the track start before the read
            if (mode == MODE_PENDING) begin
              mode     = MODE_PLAYING;
              position = start_tab[cur_track];
            end
            e.read_valid   = 1'b1;
            e.read_address = position;
            next_pos = {1'b0, position} + (ADDR_W + 1)'(CHUNK_BYTES);
            is_last  = (cur_track == TRACK_IDX_W'(TRACK_COUNT - 1));
            if (kind_tab[cur_track] == KIND_EMPTY)
              end_addr = start_tab[cur_track];
            else if (is_last || kind_tab[cur_track + 1'b1] == KIND_EMPTY)
              end_addr = disc_size;
            else
              end_addr = start_tab[cur_track + 1'b1];
            if (next_pos > {1'b0, end_addr}) begin
              if (repeat_on) begin
                position    = start_tab[cur_track];
                e.end_event = EV_LOOPED;
              end else begin
                // keep reading on sequentially, saturating at the top
                position = next_pos[ADDR_W] ? '1 : next_pos[ADDR_W-1:0];
                if (is_last) begin
                  mode        = MODE_STOPPED;
                  e.end_event = EV_STOPPED;
                end else begin
                  cur_track = cur_track + 1'b1;
                  if (kind_tab[cur_track] == KIND_EMPTY) begin
                    mode        = MODE_STOPPED;
                    e.end_event = EV_STOPPED;
                  end else begin
                    e.end_event = EV_ADVANCED;
                  end
                end
              end
            end else begin
              position = next_pos[ADDR_W-1:0];
            end
          end
        end
        default: ;
      endcase
      e.playing_track = TRACK_OUT_W'(cur_track);
      e.play_status   = mode;
      pending_status.push_back(e);
    endfunction

    // Compare one accepted status word against the oldest expectation
    function void check_status(status_word_t got);
      status_word_t exp;
      if (pending_status.size() == 0) begin
        $error("status word arrived with nothing expected");
        fail_count++;
        return;
      end
      exp = pending_status.pop_front();
      if (got.read_valid !== exp.read_valid) begin
        $error("read_valid: expected %0d, got %0d", exp.read_valid, got.read_valid);
        fail_count++;
      end
      if (got.read_address !== exp.read_address) begin
        $error("read_address: expected %h, got %h", exp.read_address, got.read_address);
        fail_count++;
      end
      if (got.playing_track !== exp.playing_track) begin
        $error("playing_track: expected %0d, got %0d", exp.playing_track,
               got.playing_track);
        fail_count++;
      end
      if (got.play_status !== exp.play_status) begin
        $error("play_status: expected %0d, got %0d", exp.play_status, got.play_status);
        fail_count++;
      end
      if (got.end_event !== exp.end_event) begin
        $error("end_event: expected %0d, got %0d", exp.end_event, got.end_event);
        fail_count++;
      end
      if (got.rejected !== exp.rejected) begin
        $error("rejected: expected %0d, got %0d", exp.rejected, got.rejected);
        fail_count++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [ADDR_W-1:0] cfg_wdata;

  dtps_in_if  in_ch ();
  dtps_out_if out_ch ();

  disc_track_playback_sequencer uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  playback_scoreboard sb;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  bit hold_request   = 1'b0;
  int hold_left      = 0;
  int cycle_count    = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Give up when the run takes far longer than any correct one
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Check every status word taken off the result channel
  always @(posedge clk) begin
    status_word_t got;
    if (rst_n && sb != null && out_ch.valid === 1'b1 && out_ch.ready) begin
      got.read_valid    = out_ch.read_valid;
      got.read_address  = out_ch.read_address;
      got.playing_track = out_ch.playing_track;
      got.play_status   = out_ch.play_status;
      got.end_event     = out_ch.end_event;
      got.rejected      = out_ch.rejected;
      sb.check_status(got);
    end
  end

  function automatic command_word_t make_word(logic [ACTION_W-1:0] action,
                                              logic [INDEX_W-1:0] idx,
                                              logic [ADDR_W-1:0] offset,
                                              logic [KIND_W-1:0] kind,
                                              logic loop_flag);
    command_word_t w;
    w.action       = action;
    w.track_index  = idx;
    w.entry_offset = offset;
    w.entry_kind   = kind;
    w.loop_flag    = loop_flag;
    return w;
  endfunction

  // Offer one word, idling first at random, and hold it until taken
  task automatic send_word(input command_word_t w);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.action       <= w.action;
    in_ch.track_index  <= w.track_index;
    in_ch.entry_offset <= w.entry_offset;
    in_ch.entry_kind   <= w.entry_kind;
    in_ch.loop_flag    <= w.loop_flag;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_command(w);
  endtask

  // Stop offering and wait for every outstanding status word
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (!sb.idle()) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_disc_size(input logic [ADDR_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.set_disc_size(v);
  endtask

  // Fill the whole table with rising offsets from base, some entries empty
  task automatic load_table(input logic [ADDR_W-1:0] base);
    logic [ADDR_W-1:0] offset;
    logic [KIND_W-1:0] kind;
    int                r;
    offset = base;
    for (int i = 0; i < TRACK_COUNT; i++) begin
      r = $urandom_range(19);
      if (r < 3)       kind = KIND_EMPTY;
      else if (r == 3) kind = KIND_BAD;
      else             kind = KIND_W'($urandom_range(1, 2));
      send_word(make_word(ACT_LOAD, INDEX_W'(i), offset, kind, 1'($urandom())));
      offset = offset + ADDR_W'($urandom_range(0, 90000));
    end
  endtask

  // Mostly ticks over the loaded table, with transport words and reloads mixed in
  function automatic command_word_t random_command(logic [ADDR_W-1:0] base);
    command_word_t w;
    int            r;
    w.action       = ACT_TICK;
    w.track_index  = INDEX_W'($urandom());
    w.entry_offset = ADDR_W'($urandom());
    w.entry_kind   = KIND_W'($urandom());
    w.loop_flag    = 1'($urandom());
    r = $urandom_range(99);
    if (r < 55) begin
      w.action = ACT_TICK;
    end else if (r < 67) begin
      w.action      = ACT_PLAY;
      w.track_index = ($urandom_range(9) == 0) ? INDEX_W'($urandom_range(32, 255))
                                               : INDEX_W'($urandom_range(31));
      w.loop_flag   = ($urandom_range(9) < 3);
    end else if (r < 72) begin
      w.action = ACT_STOP;
    end else if (r < 77) begin
      w.action = ACT_PAUSE;
    end else if (r < 84) begin
      w.action = ACT_RESUME;
    end else begin
      w.action = ACT_LOAD;
      if ($urandom_range(9) != 0)
        w.track_index = INDEX_W'($urandom_range(31));
      if ($urandom_range(1) == 0)
        w.entry_offset = base + ADDR_W'($urandom_range(0, 3000000));
    end
    return w;
  endfunction

  initial begin
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] size;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.action       = ACT_LOAD;
    in_ch.track_index  = '0;
    in_ch.entry_offset = '0;
    in_ch.entry_kind   = KIND_EMPTY;
    in_ch.loop_flag    = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    sb = new();

    // Directed: silence, resume with no play, each end event, rejects, overflow
    write_disc_size('1);
    send_word(make_word(ACT_TICK,   8'd0,   '0,            KIND_EMPTY, 1'b0));
    send_word(make_word(ACT_RESUME, 8'd0,   '0,            KIND_EMPTY, 1'b0));
    send_word(make_word(ACT_TICK,   8'd0,   '0,            KIND_EMPTY, 1'b0));
    send_word(make_word(ACT_LOAD,   8'd0,   '0,            2'd1,       1'b0));
    send_word(make_word(ACT_LOAD,   8'd1,   30'd40000,     KIND_OTHER, 1'b0));
    send_word(make_word(ACT_LOAD,   8'd2,   30'd50000,     KIND_BAD,   1'b0));
    send_word(make_word(ACT_LOAD,   8'd200, '1,            2'd1,       1'b1));
    send_word(make_word(ACT_LOAD,   8'd31,  30'h3FFF_FF9C, 2'd1,       1'b0));
    send_word(make_word(ACT_PLAY,   8'd255, '0,            KIND_EMPTY, 1'b1));
    send_word(make_word(ACT_PLAY,   8'd0,   '0,            KIND_EMPTY, 1'b1));
    send_word(make_word(ACT_TICK,   8'd0,   '0,            KIND_EMPTY, 1'b0));
    send_word(make_word(ACT_TICK,   8'd0,   '0,            KIND_EMPTY, 1'b0));
    send_word(make_word(ACT_TICK,   8'd0,   '0,            KIND_EMPTY, 1'b0));
    send_word(make_word(ACT_PAUSE,  8'd0,   '0,            KIND_EMPTY, 1'b0));
    send_word(make_word(ACT_RESUME, 8'd0,   '0,            KIND_EMPTY, 1'b0));
    send_word(make_word(ACT_TICK,   8'd0,   '0,            KIND_EMPTY, 1'b0));
    send_word(make_word(ACT_STOP,   8'd0,   '0,            KIND_EMPTY, 1'b0));
    send_word(make_word(ACT_PLAY,   8'd1,   '0,            KIND_EMPTY, 1'b0));
    send_word(make_word(ACT_TICK,   8'd0,   '0,            KIND_EMPTY, 1'b0));
    send_word(make_word(ACT_TICK,   8'd0,   '0,            KIND_EMPTY, 1'b0));
    send_word(make_word(ACT_PLAY,   8'd31,  '0,            KIND_EMPTY, 1'b0));
    send_word(make_word(ACT_TICK,   8'd0,   '0,            KIND_EMPTY, 1'b0));
    send_word(make_word(ACT_RESUME, 8'd0,   '0,            KIND_EMPTY, 1'b0));
    send_word(make_word(ACT_TICK,   8'd0,   '0,            KIND_EMPTY, 1'b0));
    send_word(make_word(ACT_LOAD,   8'd31,  '0,            KIND_EMPTY, 1'b0));

    // Random phases: rotate idling style and disc size, reload the table each time
    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p == 3 || p == 6)
        base = '1 - ADDR_W'($urandom_range(0, 1500000));
      else if (p == 0)
        base = '0;
      else
        base = ADDR_W'($urandom_range(0, 1 << 24));
      case ((p / 2) % 4)
        0:       size = '1;
        1:       size = '0;
        2:       size = base + ADDR_W'($urandom_range(0, 32 * 60000));
        default: size = ADDR_W'($urandom());
      endcase
      write_disc_size(size);
      case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 71; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 71; end
        default: begin src_idle_pct = 33; sink_stall_pct = 33; end
      endcase
      load_table(base);
      for (int n = 0; n < RANDOM_WORDS; n++) begin
        // hold the receiver off while the sender keeps pushing
        if (p % 4 == 0 && n == 40)
          hold_request = 1'b1;
        // let everything drain before carrying on
        if (p == 1 && n == 60)
          drain();
        send_word(random_command(base));
      end
    end

    drain();
    if (sb.fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sim.f @@
design/dtps_pkg.sv
design/dtps_if.sv
design/dtps_front.sv
design/dtps_back.sv
design/disc_track_playback_sequencer.sv
sim/testbench.sv
